// ===== rtl/cbs_pkg.sv =====
// Package for the per-channel CFA box-sum block: widths, register indexes, result type, count helper.
// No dependencies.
`default_nettype none
package cbs_pkg;
   localparam int NCH = 4;
   localparam int PIX_W = 16;
   localparam int RWS_W = 24;
   localparam int CRS_W = 29;
   localparam int SUM_W = 28;
   localparam int CNT_W = 13;
   localparam int POS_W = 10;
   localparam int MAX_ROWS = 1024;
   localparam int MAX_PATCH = 64;

   typedef enum logic [2:0] {
      REG_IMAGE_ROWS = 3'd0,
      REG_IMAGE_COLS = 3'd1,
      REG_CFA_ROWS   = 3'd2,
      REG_CFA_COLS   = 3'd3,
      REG_PATCH_ROWS = 3'd4,
      REG_PATCH_COLS = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic                frame_last;
      logic [CNT_W-1:0]    count_ch3;
      logic [CNT_W-1:0]    count_ch2;
      logic [CNT_W-1:0]    count_ch1;
      logic [CNT_W-1:0]    count_ch0;
      logic [SUM_W-1:0]    sum_ch3;
      logic [SUM_W-1:0]    sum_ch2;
      logic [SUM_W-1:0]    sum_ch1;
      logic [SUM_W-1:0]    sum_ch0;
      logic [POS_W-1:0]    win_col;
      logic [POS_W-1:0]    win_row;
   } result_type;

   // Pixels of a given residue in a run of len positions starting at start (period 1 or 2).
   function automatic logic [6:0] res_count(input logic start0, input logic [6:0] len,
                                            input logic two, input logic res);
      logic [6:0] n;
      begin
         n = 7'd0;
         if (!two) begin
            n = len;
         end else if (start0 == res) begin
            n = 7'((8'(len) + 8'd1) >> 1);
         end else begin
            n = len >> 1;
         end
         return n;
      end
   endfunction
endpackage
`default_nettype wire

// ===== rtl/cfa_channel_box_sum.sv =====
// Per-channel box sums over a CFA mosaic, column-major pixel stream.
// Pipeline: the taking edge issues the memory reads, stage 1 updates the row sum, stage 2
// the column sum and loads the output queue, from which the result is presented.
// Throughput: one pixel per cycle; req_tready drops only while the 4-entry
// output queue plus the two pipeline stages would hold more than four results.
// Reset (synchronous): registers to defaults, counters and sums to zero; the row-sum
// memory is not cleared: a row is zeroed in column 0 before it is read.
// Uses cbs_pkg and cbs_ram.
`default_nettype none
module cfa_channel_box_sum
   import cbs_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [15:0]  req_tdata,   // pixel_value
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [183:0] rsp_tdata,   // win_row, win_col, sum_ch0..3, count_ch0..3
   output logic         rsp_tlast,   // frame_last
   input  wire          csr_wr_en,
   input  wire  [2:0]   csr_index,
   input  wire  [10:0]  csr_wdata
);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int PW = $clog2(MAX_PATCH);
   localparam int HW = RW + PW;

   // configuration
   logic [10:0] img_rows_ff, img_cols_ff;
   logic [1:0]  cfa_rows_ff, cfa_cols_ff;
   logic [6:0]  pat_rows_ff, pat_cols_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         img_rows_ff <= 11'd1024; img_cols_ff <= 11'd1024;
         cfa_rows_ff <= 2'd2; cfa_cols_ff <= 2'd2;
         pat_rows_ff <= 7'd8; pat_cols_ff <= 7'd8;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_IMAGE_ROWS: img_rows_ff <= csr_wdata;
            REG_IMAGE_COLS: img_cols_ff <= csr_wdata;
            REG_CFA_ROWS:   cfa_rows_ff <= csr_wdata[1:0];
            REG_CFA_COLS:   cfa_cols_ff <= csr_wdata[1:0];
            REG_PATCH_ROWS: pat_rows_ff <= csr_wdata[6:0];
            REG_PATCH_COLS: pat_cols_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end
   wire cfg_hit = csr_wr_en && (csr_index <= 3'(REG_PATCH_COLS));

   // clamped settings
   logic [10:0] rows_c, cols_c;
   logic        cr2, cc2;
   logic [6:0]  pr_c, pc_c;
   always_comb begin
      logic [10:0] lim;
      rows_c = (img_rows_ff == 11'd0) ? 11'd1 :
               (img_rows_ff > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : img_rows_ff;
      cols_c = (img_cols_ff == 11'd0) ? 11'd1 :
               (img_cols_ff > 11'd1024) ? 11'd1024 : img_cols_ff;
      cr2 = cfa_rows_ff >= 2'd2;
      cc2 = cfa_cols_ff >= 2'd2;
      lim = (rows_c < 11'(MAX_PATCH)) ? rows_c : 11'(MAX_PATCH);
      pr_c = (pat_rows_ff == 7'd0) ? 7'd1 :
             (11'(pat_rows_ff) > lim) ? 7'(lim) : pat_rows_ff;
      lim = (cols_c < 11'(MAX_PATCH)) ? cols_c : 11'(MAX_PATCH);
      pc_c = (pat_cols_ff == 7'd0) ? 7'd1 :
             (11'(pat_cols_ff) > lim) ? 7'(lim) : pat_cols_ff;
   end

   // stage 0: counters, memory reads
   logic [RW-1:0] r_ff;
   logic [9:0]    c_ff;
   logic [6:0]    cm_ff;            // c mod pc
   wire           take = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         r_ff <= '0; c_ff <= '0; cm_ff <= '0;
      end else if (take) begin
         if (11'(r_ff) + 11'd1 >= rows_c) begin
            r_ff <= '0;
            if (11'(c_ff) + 11'd1 >= cols_c) begin
               c_ff <= '0; cm_ff <= '0;
            end else begin
               c_ff <= c_ff + 10'd1;
               cm_ff <= (cm_ff + 7'd1 >= pc_c) ? 7'd0 : cm_ff + 7'd1;
            end
         end else begin
            r_ff <= r_ff + RW'(1);
         end
      end
   end

   // pipeline stage 1 registers (item after memory read issue)
   logic          v1_ff, v2_ff, v3_ff;
   logic [RW-1:0] r1_ff, r2_ff, r3_ff;
   logic [9:0]    c1_ff, c2_ff;
   logic [15:0]   pix1_ff;
   logic [15:0]   hist_rd;
   logic [RWS_W-1:0] rws_rd [NCH];
   logic [RWS_W-1:0] old_rd [NCH];
   logic [RWS_W-1:0] rws2_ff [NCH];  // updated row sums of stage 2
   logic [RWS_W-1:0] old2_ff [NCH];
   logic [RWS_W-1:0] rws3_ff [NCH];  // row sums written at the last edge

   wire [HW-1:0] hslot = {r_ff, cm_ff[PW-1:0]};
   wire [RW-1:0] r_old = r_ff - RW'(pr_c);

   cbs_ram #(.WIDTH(16), .DEPTH(MAX_ROWS*MAX_PATCH)) u_hist (
      .clock(clock), .wr_en(take), .wr_addr(hslot), .wr_data(req_tdata),
      .rd_addr(hslot), .rd_data(hist_rd));

   // row sums: two memories per channel, both written at stage 2; one reads row r, the other row r-pr
   genvar g;
   generate
      for (g = 0; g < NCH; g++) begin : g_rws
         cbs_ram #(.WIDTH(RWS_W), .DEPTH(MAX_ROWS)) u_cur (
            .clock(clock), .wr_en(v2_ff), .wr_addr(r2_ff), .wr_data(rws2_ff[g]),
            .rd_addr(r_ff), .rd_data(rws_rd[g]));
         cbs_ram #(.WIDTH(RWS_W), .DEPTH(MAX_ROWS)) u_old (
            .clock(clock), .wr_en(v2_ff), .wr_addr(r2_ff), .wr_data(rws2_ff[g]),
            .rd_addr(r_old), .rd_data(old_rd[g]));
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= take;
      end
      if (take) begin
         r1_ff <= r_ff; c1_ff <= c_ff; pix1_ff <= req_tdata;
      end
   end

   // stage 1: row sum update; forward the row still in stage 2 or written at the
   // edge that issued this read, newest first
   logic [RWS_W-1:0] rws_new [NCH];
   logic [RWS_W-1:0] old_fw [NCH];
   always_comb begin
      logic [RWS_W-1:0] base;
      logic [1:0] ch, och;
      logic [9:0] cold;
      logic [6:0] pc1;
      logic [RW-1:0] rold;
      pc1 = pc_c;
      cold = c1_ff - 10'(pc1);
      rold = r1_ff - RW'(pr_c);
      ch  = {cc2 & c1_ff[0], 1'b0} + (cr2 ? {1'b0, r1_ff[0]} : 2'd0);
      if (!cr2) ch = {1'b0, cc2 & c1_ff[0]};
      och = cr2 ? {cc2 & cold[0], r1_ff[0]} : {1'b0, cc2 & cold[0]};
      for (int k = 0; k < NCH; k++) begin
         base = rws_rd[k];
         if (v3_ff && r3_ff == r1_ff) base = rws3_ff[k];
         if (v2_ff && r2_ff == r1_ff) base = rws2_ff[k];
         if (c1_ff == 10'd0) base = '0;
         if (11'(c1_ff) >= 11'(pc1) && och == 2'(k)) base = base - RWS_W'(hist_rd);
         if (ch == 2'(k)) base = base + RWS_W'(pix1_ff);
         rws_new[k] = base;
         old_fw[k] = old_rd[k];
         if (v3_ff && r3_ff == rold) old_fw[k] = rws3_ff[k];
         if (v2_ff && r2_ff == rold) old_fw[k] = rws2_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (v1_ff) begin
         r2_ff <= r1_ff; c2_ff <= c1_ff;
         for (int k = 0; k < NCH; k++) begin
            rws2_ff[k] <= rws_new[k];
            old2_ff[k] <= old_fw[k];
         end
      end
      if (v2_ff) begin
         r3_ff <= r2_ff;
         for (int k = 0; k < NCH; k++) rws3_ff[k] <= rws2_ff[k];
      end
   end

   // stage 2: column running sums
   logic [CRS_W-1:0] crs_ff [NCH];
   logic [CRS_W-1:0] crs_in [NCH];
   always_comb begin
      for (int k = 0; k < NCH; k++) begin
         crs_in[k] = (r2_ff == '0) ? '0 : crs_ff[k];
         crs_in[k] = crs_in[k] + CRS_W'(rws2_ff[k]);
         if (11'(r2_ff) >= 11'(pr_c)) crs_in[k] = crs_in[k] - CRS_W'(old2_ff[k]);
      end
   end
   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         for (int k = 0; k < NCH; k++) crs_ff[k] <= '0;
      end else if (v2_ff) begin
         for (int k = 0; k < NCH; k++) crs_ff[k] <= crs_in[k];
      end
   end

   // result assembly for the output queue
   result_type res;
   logic emit;
   always_comb begin
      logic [9:0] r0, c0;
      logic [6:0] ra, rb;
      r0 = 10'(r2_ff) + 10'd1 - 10'(pr_c);
      c0 = c2_ff + 10'd1 - 10'(pc_c);
      emit = v2_ff && (11'(r2_ff) + 11'd1 >= 11'(pr_c)) && (11'(c2_ff) + 11'd1 >= 11'(pc_c));
      res = '0;
      res.win_row = r0;
      res.win_col = c0;
      res.frame_last = (11'(r2_ff) == rows_c - 11'd1) && (11'(c2_ff) == cols_c - 11'd1);
      for (int k = 0; k < NCH; k++) begin
         logic a, b, used;
         a = cr2 ? k[0] : 1'b0;
         b = cr2 ? k[1] : k[0];
         used = cr2 ? (!k[1] || cc2) : (k < 2 && (!k[0] || cc2));
         ra = res_count(r0[0], pr_c, cr2, a);
         rb = res_count(c0[0], pc_c, cc2, b);
         if (used) begin
            case (k)
               0: begin res.sum_ch0 = crs_in[k][SUM_W-1:0];
                  res.count_ch0 = CNT_W'(ra) * CNT_W'(rb); end
               1: begin res.sum_ch1 = crs_in[k][SUM_W-1:0];
                  res.count_ch1 = CNT_W'(ra) * CNT_W'(rb); end
               2: begin res.sum_ch2 = crs_in[k][SUM_W-1:0];
                  res.count_ch2 = CNT_W'(ra) * CNT_W'(rb); end
               default: begin res.sum_ch3 = crs_in[k][SUM_W-1:0];
                  res.count_ch3 = CNT_W'(ra) * CNT_W'(rb); end
            endcase
         end
      end
   end

   // output queue of 4 results; items in the pipe reserve their entry
   result_type q_ff [4];
   logic [2:0] cnt_ff;
   logic [1:0] wp_ff, rp_ff;
   wire pop = rsp_tvalid && rsp_tready;
   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         cnt_ff <= '0; wp_ff <= '0; rp_ff <= '0;
      end else begin
         if (emit) begin
            q_ff[wp_ff] <= res; wp_ff <= wp_ff + 2'd1;
         end
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(emit) - 3'(pop);
      end
   end
   // in flight (v1, v2) plus stored must fit in 4
   assign req_tready = (cnt_ff + 3'(v1_ff) + 3'(v2_ff)) < 3'd4;
   assign rsp_tvalid = cnt_ff != 3'd0;
   assign rsp_tlast  = q_ff[rp_ff].frame_last;
   assign rsp_tdata  = q_ff[rp_ff][183:0];
endmodule
`default_nettype wire

// ===== rtl/cbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module cbs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
